[rtl/trlc_pkg.sv]
// ----------------------------------------------------------------------------
// trlc_pkg
// Types, constants and lamp tables for the two-road traffic light controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trlc_pkg;

  localparam int unsigned TimeW = 7;
  localparam int unsigned DispW = 8;
  localparam int unsigned LampW = 3;

  localparam logic [TimeW-1:0] EditMax       = 7'd99;
  localparam logic [TimeW-1:0] EditMin       = 7'd1;
  localparam logic [TimeW-1:0] RedTimeRst    = 7'd5;
  localparam logic [TimeW-1:0] YellowTimeRst = 7'd2;
  localparam logic [TimeW-1:0] GreenTimeRst  = 7'd3;

  // lamp bit positions: red, yellow, green
  localparam logic [LampW-1:0] LampOff    = 3'b000;
  localparam logic [LampW-1:0] LampRed    = 3'b100;
  localparam logic [LampW-1:0] LampYellow = 3'b010;
  localparam logic [LampW-1:0] LampGreen  = 3'b001;

  // pending event bits
  localparam int unsigned PendTick   = 0;
  localparam int unsigned PendBlink  = 1;
  localparam int unsigned PendModify = 2;
  localparam int unsigned PendSet    = 3;

  typedef enum logic [2:0] {
    MODE_INIT        = 3'd0,
    MODE_RUN         = 3'd1,
    MODE_EDIT_RED    = 3'd2,
    MODE_EDIT_YELLOW = 3'd3,
    MODE_EDIT_GREEN  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    PH_INIT      = 3'd0,
    PH_R1_GREEN  = 3'd1,
    PH_R1_AMBER  = 3'd2,
    PH_R2_GREEN  = 3'd3,
    PH_R2_AMBER  = 3'd4
  } phase_e;

  function automatic logic [LampW-1:0] road1_lamp(input phase_e ph);
    logic [LampW-1:0] l;
    case (ph)
      PH_R1_GREEN: l = LampGreen;
      PH_R1_AMBER: l = LampYellow;
      PH_R2_GREEN: l = LampRed;
      PH_R2_AMBER: l = LampRed;
      default:     l = LampOff;
    endcase
    return l;
  endfunction

  function automatic logic [LampW-1:0] road2_lamp(input phase_e ph);
    logic [LampW-1:0] l;
    case (ph)
      PH_R1_GREEN: l = LampRed;
      PH_R1_AMBER: l = LampRed;
      PH_R2_GREEN: l = LampGreen;
      PH_R2_AMBER: l = LampYellow;
      default:     l = LampOff;
    endcase
    return l;
  endfunction

endpackage

[rtl/two_road_traffic_light_controller.sv]
// Each input transfer's result is registered and appears on the output in the next cycle.
// Throughput: one item per cycle while the output is not stalled; the state update is a single registered pass.
// Input is stalled only while a result is held by a stalled output.
// Reset (asynchronous, active low): init mode, all lamps off, display zero,
// durations red 5, yellow 2, green 3, no events pending, output empty.
// ----------------------------------------------------------------------------
// two_road_traffic_light_controller
// Two-road light sequencer with countdown display and editable durations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_road_traffic_light_controller
  import trlc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             second_tick_i,
  input  logic             blink_tick_i,
  input  logic             mode_press_i,
  input  logic             modify_press_i,
  input  logic             set_press_i,

  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [LampW-1:0] road1_lights_o,
  output logic [LampW-1:0] road2_lights_o,
  output logic [DispW-1:0] display_left_o,
  output logic [DispW-1:0] display_right_o,
  output logic [2:0]       operating_mode_o
);

  mode_e            mode_q, mode_d;
  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] cd_q, cd_d;
  logic [TimeW-1:0] red_q, red_d;
  logic [TimeW-1:0] yel_q, yel_d;
  logic [TimeW-1:0] grn_q, grn_d;
  logic [TimeW-1:0] edit_q, edit_d;
  logic [LampW-1:0] lamp1_q, lamp1_d;
  logic [LampW-1:0] lamp2_q, lamp2_d;
  logic [DispW-1:0] left_q, left_d;
  logic [DispW-1:0] right_q, right_d;
  logic [3:0]       pend_q, pend_d;
  logic             out_valid_q;

  logic             in_xfer;
  logic [DispW-1:0] cd_wide;
  logic [DispW-1:0] cd_plus_yel;
  logic [DispW-1:0] edit_inc;
  logic [LampW-1:0] edit_lamp;
  logic [DispW-1:0] edit_code;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    cd_d    = cd_q;
    red_d   = red_q;
    yel_d   = yel_q;
    grn_d   = grn_q;
    edit_d  = edit_q;
    lamp1_d = lamp1_q;
    lamp2_d = lamp2_q;
    left_d  = left_q;
    right_d = right_q;
    pend_d  = pend_q | {set_press_i, modify_press_i, blink_tick_i, second_tick_i};
    cd_wide     = '0;
    cd_plus_yel = '0;
    edit_inc    = '0;
    edit_lamp   = LampOff;
    edit_code   = '0;

    if (mode_press_i) begin
      case (mode_q)
        MODE_RUN: begin
          mode_d  = MODE_EDIT_RED;
          lamp1_d = LampOff;
          lamp2_d = LampOff;
          edit_d  = red_q;
        end
        MODE_EDIT_RED: begin
          mode_d  = MODE_EDIT_YELLOW;
          lamp1_d = LampOff;
          lamp2_d = LampOff;
          edit_d  = yel_q;
        end
        MODE_EDIT_YELLOW: begin
          mode_d  = MODE_EDIT_GREEN;
          lamp1_d = LampOff;
          lamp2_d = LampOff;
          edit_d  = grn_q;
        end
        MODE_EDIT_GREEN: begin
          mode_d  = MODE_RUN;
          phase_d = PH_INIT;
        end
        default: ;
      endcase
    end

    case (mode_d)
      MODE_INIT: begin
        mode_d = MODE_RUN;
      end
      MODE_RUN: begin
        if (phase_d == PH_INIT) begin
          cd_d    = grn_q;
          phase_d = PH_R1_GREEN;
        end else if (phase_d <= PH_R2_AMBER) begin
          lamp1_d = road1_lamp(phase_d);
          lamp2_d = road2_lamp(phase_d);
          if (pend_d[PendTick]) begin
            pend_d[PendTick] = 1'b0;
            if (cd_d != '0) begin
              cd_d = cd_d - 1'b1;
            end
          end
          cd_wide     = {1'b0, cd_d};
          cd_plus_yel = {1'b0, cd_d} + {1'b0, yel_q};
          left_d  = cd_wide;
          right_d = cd_wide;
          case (phase_d)
            PH_R1_GREEN: begin
              if (cd_d == '0) begin
                cd_d    = yel_q;
                phase_d = PH_R1_AMBER;
                left_d  = {1'b0, yel_q} + {1'b0, yel_q};
                right_d = {1'b0, yel_q};
              end else begin
                left_d = cd_plus_yel;
              end
            end
            PH_R1_AMBER: begin
              if (cd_d == '0) begin
                cd_d    = grn_q;
                phase_d = PH_R2_GREEN;
                left_d  = {1'b0, grn_q};
                right_d = {1'b0, grn_q};
              end
            end
            PH_R2_GREEN: begin
              if (cd_d == '0) begin
                cd_d    = yel_q;
                phase_d = PH_R2_AMBER;
                left_d  = {1'b0, yel_q};
                right_d = {1'b0, yel_q} + {1'b0, yel_q};
              end else begin
                right_d = cd_plus_yel;
              end
            end
            PH_R2_AMBER: begin
              if (cd_d == '0) begin
                cd_d    = grn_q;
                phase_d = PH_R1_GREEN;
                left_d  = {1'b0, grn_q};
                right_d = {1'b0, grn_q};
              end
            end
            default: ;
          endcase
        end
      end
      MODE_EDIT_RED, MODE_EDIT_YELLOW, MODE_EDIT_GREEN: begin
        case (mode_d)
          MODE_EDIT_RED:    edit_lamp = LampRed;
          MODE_EDIT_YELLOW: edit_lamp = LampYellow;
          default:          edit_lamp = LampGreen;
        endcase
        edit_code = {{(DispW-3){1'b0}}, mode_d};
        if (pend_d[PendBlink]) begin
          pend_d[PendBlink] = 1'b0;
          left_d  = edit_code;
          right_d = {1'b0, edit_d};
          lamp1_d = lamp1_d ^ edit_lamp;
          lamp2_d = lamp2_d ^ edit_lamp;
        end
        if (pend_d[PendModify]) begin
          pend_d[PendModify] = 1'b0;
          edit_inc = {1'b0, edit_d} + 1'b1;
          if (edit_inc > {1'b0, EditMax}) begin
            edit_d = EditMin;
          end else begin
            edit_d = edit_inc[TimeW-1:0];
          end
        end
        if (pend_d[PendSet]) begin
          pend_d[PendSet] = 1'b0;
          case (mode_d)
            MODE_EDIT_RED:    red_d = edit_d;
            MODE_EDIT_YELLOW: yel_d = edit_d;
            default:          grn_d = edit_d;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_INIT;
      phase_q     <= PH_INIT;
      cd_q        <= '0;
      red_q       <= RedTimeRst;
      yel_q       <= YellowTimeRst;
      grn_q       <= GreenTimeRst;
      edit_q      <= '0;
      lamp1_q     <= LampOff;
      lamp2_q     <= LampOff;
      left_q      <= '0;
      right_q     <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        mode_q  <= mode_d;
        phase_q <= phase_d;
        cd_q    <= cd_d;
        red_q   <= red_d;
        yel_q   <= yel_d;
        grn_q   <= grn_d;
        edit_q  <= edit_d;
        lamp1_q <= lamp1_d;
        lamp2_q <= lamp2_d;
        left_q  <= left_d;
        right_q <= right_d;
        pend_q  <= pend_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign road1_lights_o   = lamp1_q;
  assign road2_lights_o   = lamp2_q;
  assign display_left_o   = left_q;
  assign display_right_o  = right_q;
  assign operating_mode_o = mode_q;

`ifndef SYNTH
  a_xfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("transfer did not produce a result");

  a_running_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_RUN && phase_q != PH_INIT) |-> (cd_q != '0))
    else $error("countdown at zero while sequencing");

  a_edit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_EDIT_RED || mode_q == MODE_EDIT_YELLOW ||
     mode_q == MODE_EDIT_GREEN) |-> (edit_q >= EditMin && edit_q <= EditMax))
    else $error("edited duration out of range");

  a_edit_consumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_EDIT_RED || mode_q == MODE_EDIT_YELLOW ||
     mode_q == MODE_EDIT_GREEN) |-> (pend_q[PendSet:PendBlink] == '0))
    else $error("edit events left pending");
`endif

endmodule
